>>> rtl/lrq_pkg.sv
// Shared types and constants for the look-rotation quaternion unit.
// No dependencies.
package lrq_pkg;

  localparam int COMPONENT_BITS = 16;            // input component width, Q3.12
  localparam int QUAT_BITS      = 16;            // output component width, Q1.14
  localparam int FRAC           = 30;            // internal unit vectors are Q1.30
  localparam int UNIT_W         = FRAC + 2;      // signed Q1.30 container
  localparam int Q_W            = UNIT_W + 4;    // matrix terms and raw quaternion
  localparam int QUAT_ONE       = 1 << (QUAT_BITS - 2);
  localparam int OUT_SHIFT      = FRAC - (QUAT_BITS - 2);

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] forward_x;
    logic signed [COMPONENT_BITS-1:0] forward_y;
    logic signed [COMPONENT_BITS-1:0] forward_z;
    logic signed [COMPONENT_BITS-1:0] up_x;
    logic signed [COMPONENT_BITS-1:0] up_y;
    logic signed [COMPONENT_BITS-1:0] up_z;
  } lrq_in_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } lrq_out_t;

endpackage

>>> rtl/lrq_norm.sv
// Pipelined vector normalizer: N signed lanes to Q1.30 unit components.
// Leading-one shift, squares, 1-bit/stage square root, 1-bit/stage dividers.
// Depends on lrq_pkg.
module lrq_norm #(
  parameter int N  = 3,     // lanes, at most 4
  parameter int VW = 16,    // input lane width, two's complement
  parameter int SW = 1      // side data carried alongside
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic [N-1:0][VW-1:0]                val_i,
  input  logic [SW-1:0]                       side_i,
  output logic                                vld_o,
  output logic [N-1:0][lrq_pkg::UNIT_W-1:0]   unit_o,
  output logic [SW-1:0]                       side_o
);
  import lrq_pkg::*;

  localparam int PW      = $clog2(VW);
  localparam int MW      = FRAC + 1;       // normalized magnitude in [2^30, 2^31)
  localparam int SUM_W   = 2 * MW + 2;
  localparam int ROOT_W  = MW + 1;
  localparam int QW      = MW;             // quotient bits, value <= 2^30
  localparam int DREM_W  = 64;

  // ---- stage 0: magnitudes
  logic [N-1:0][VW-1:0] mag0_r;
  logic [N-1:0]         neg0_r;
  logic [SW-1:0]        side0_r;
  logic                 vld0_r;

  // ---- stage 1: leading one of the OR of all magnitudes
  logic [VW-1:0]        orv;
  logic [PW-1:0]        lead;
  logic [N-1:0][VW-1:0] mag1_r;
  logic [N-1:0]         neg1_r;
  logic [PW-1:0]        lead1_r;
  logic                 zero1_r;
  logic [SW-1:0]        side1_r;
  logic                 vld1_r;

  // ---- stage 2: shift so the largest lies in [2^30, 2^31)
  logic [N-1:0][VW+FRAC-1:0] ext;
  logic [N-1:0][MW-1:0]      nm2_r;
  logic [N-1:0]              neg2_r;
  logic                      zero2_r;
  logic [SW-1:0]             side2_r;
  logic                      vld2_r;

  // ---- stage 3: squares
  logic [N-1:0][2*MW-1:0] sq3_r;
  logic [N-1:0][MW-1:0]   nm3_r;
  logic [N-1:0]           neg3_r;
  logic                   zero3_r;
  logic [SW-1:0]          side3_r;
  logic                   vld3_r;

  // ---- square root stages; index 0 holds the sum
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]    root_r [0:ROOT_W];
  logic [N-1:0][MW-1:0] snm_r  [0:ROOT_W];
  logic [N-1:0]         sneg_r [0:ROOT_W];
  logic                 szero_r[0:ROOT_W];
  logic [SW-1:0]        sside_r[0:ROOT_W];
  logic                 svld_r [0:ROOT_W];
  logic [SUM_W:0]       sq_trial[1:ROOT_W];
  logic                 sq_take [1:ROOT_W];

  // ---- divider stages; index 0 holds the rounded numerators
  logic [N-1:0][DREM_W-1:0] drem_r [0:QW];
  logic [N-1:0][QW-1:0]     dquo_r [0:QW];
  logic [DREM_W-1:0]        dlen_r [0:QW];
  logic [N-1:0]             dneg_r [0:QW];
  logic                     dzero_r[0:QW];
  logic [SW-1:0]            dside_r[0:QW];
  logic                     dvld_r [0:QW];
  logic [N-1:0][DREM_W-1:0] dv_trial[1:QW];
  logic [N-1:0]             dv_take [1:QW];

  logic [N-1:0][UNIT_W-1:0] unit_r;
  logic [SW-1:0]            side_r;
  logic                     vld_r;

  always_comb begin
    orv  = '0;
    lead = '0;
    for (int i = 0; i < N; i++) orv |= mag0_r[i];
    for (int b = 0; b < VW; b++) begin
      if (orv[b]) lead = PW'(b);
    end
    for (int i = 0; i < N; i++) ext[i] = {mag1_r[i], {FRAC{1'b0}}} >> lead1_r;
    sum = '0;
    for (int i = 0; i < N; i++) sum = sum + SUM_W'(sq3_r[i]);
  end

  // trial subtrahend of each root bit: (root << (b+1)) + 4^b
  always_comb begin
    for (int k = 1; k <= ROOT_W; k++) begin
      sq_trial[k] = ((SUM_W+1)'(root_r[k-1]) << (ROOT_W - k + 1))
                  + ((SUM_W+1)'(1) << (2 * (ROOT_W - k)));
      sq_take[k]  = {1'b0, rem_r[k-1]} >= sq_trial[k];
    end
    for (int k = 1; k <= QW; k++) begin
      for (int i = 0; i < N; i++) begin
        dv_trial[k][i] = dlen_r[k-1] << (QW - k);
        dv_take[k][i]  = drem_r[k-1][i] >= dv_trial[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) svld_r[k] <= 1'b0;
      for (int k = 0; k <= QW; k++) dvld_r[k] <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      vld0_r    <= vld_i;
      vld1_r    <= vld0_r;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      svld_r[0] <= vld3_r;
      for (int k = 1; k <= ROOT_W; k++) svld_r[k] <= svld_r[k-1];
      dvld_r[0] <= svld_r[ROOT_W];
      for (int k = 1; k <= QW; k++) dvld_r[k] <= dvld_r[k-1];
      vld_r <= dvld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        neg0_r[i] <= val_i[i][VW-1];
        mag0_r[i] <= val_i[i][VW-1] ? (~val_i[i]) + VW'(1) : val_i[i];
      end
      side0_r <= side_i;

      mag1_r  <= mag0_r;
      neg1_r  <= neg0_r;
      lead1_r <= lead;
      zero1_r <= (orv == '0);
      side1_r <= side0_r;

      for (int i = 0; i < N; i++) nm2_r[i] <= ext[i][MW-1:0];
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      side2_r <= side1_r;

      for (int i = 0; i < N; i++) sq3_r[i] <= nm2_r[i] * nm2_r[i];
      nm3_r   <= nm2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      side3_r <= side2_r;

      rem_r[0]   <= sum;
      root_r[0]  <= '0;
      snm_r[0]   <= nm3_r;
      sneg_r[0]  <= neg3_r;
      szero_r[0] <= zero3_r;
      sside_r[0] <= side3_r;
      for (int k = 1; k <= ROOT_W; k++) begin
        rem_r[k]   <= sq_take[k] ? rem_r[k-1] - sq_trial[k][SUM_W-1:0] : rem_r[k-1];
        root_r[k]  <= sq_take[k] ? root_r[k-1] | (ROOT_W'(1) << (ROOT_W - k))
                                 : root_r[k-1];
        snm_r[k]   <= snm_r[k-1];
        sneg_r[k]  <= sneg_r[k-1];
        szero_r[k] <= szero_r[k-1];
        sside_r[k] <= sside_r[k-1];
      end

      // numerator: mag * 2^30 + len/2
      for (int i = 0; i < N; i++) begin
        drem_r[0][i] <= (DREM_W'(snm_r[ROOT_W][i]) << FRAC)
                      + DREM_W'(root_r[ROOT_W] >> 1);
      end
      dquo_r[0]  <= '0;
      dlen_r[0]  <= DREM_W'(root_r[ROOT_W]);
      dneg_r[0]  <= sneg_r[ROOT_W];
      dzero_r[0] <= szero_r[ROOT_W];
      dside_r[0] <= sside_r[ROOT_W];
      for (int k = 1; k <= QW; k++) begin
        for (int i = 0; i < N; i++) begin
          drem_r[k][i] <= dv_take[k][i] ? drem_r[k-1][i] - dv_trial[k][i]
                                        : drem_r[k-1][i];
          dquo_r[k][i] <= dv_take[k][i] ? dquo_r[k-1][i] | (QW'(1) << (QW - k))
                                        : dquo_r[k-1][i];
        end
        dlen_r[k]  <= dlen_r[k-1];
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
        dside_r[k] <= dside_r[k-1];
      end

      // all-zero vector: len is zero, quotients are meaningless
      for (int i = 0; i < N; i++) begin
        if (dzero_r[QW]) begin
          unit_r[i] <= '0;
        end else if (dneg_r[QW][i]) begin
          unit_r[i] <= -UNIT_W'(dquo_r[QW][i]);
        end else begin
          unit_r[i] <= UNIT_W'(dquo_r[QW][i]);
        end
      end
      side_r <= dside_r[QW];
    end
  end

  assign vld_o  = vld_r;
  assign unit_o = unit_r;
  assign side_o = side_r;

endmodule

>>> rtl/look_rotation_quaternion_unit.sv
// Look-rotation to quaternion: forward + up hint in, unit quaternion (Q1.14) out.
// Three normalizers, each dominated by its 32-stage root and 31-stage divider chains,
// plus 7 cross-product/branch/output stages.
// Throughput one beat per cycle when not stalled; one global stall freezes every stage together.
// Reset (rst_n low, synchronous) clears only the valid bits. Depends on lrq_pkg, lrq_norm.
module look_rotation_quaternion_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrq_pkg::lrq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lrq_pkg::lrq_out_t out_data
);
  import lrq_pkg::*;

  localparam int CW   = COMPONENT_BITS;
  localparam int P_W  = CW + UNIT_W;     // up * f product
  localparam int RC_W = P_W + 1;         // difference of two products
  localparam int G_W  = 2 * UNIT_W;      // f * r product
  localparam int ONE  = 1 << FRAC;

  typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} branch_t;

  logic en;

  // forward normalizer
  logic                       fv;
  logic [2:0][UNIT_W-1:0]     f_u;
  logic [3*CW-1:0]            f_side;

  // up x f
  logic signed [P_W-1:0]      p1_r [6];
  logic [2:0][UNIT_W-1:0]     f1_r;
  logic                       v1_r;
  logic [2:0][RC_W-1:0]       rc2_r;
  logic [2:0][UNIT_W-1:0]     f2_r;
  logic                       v2_r;

  // right normalizer
  logic                       rv;
  logic [2:0][UNIT_W-1:0]     r_u;
  logic [3*UNIT_W-1:0]        r_side;

  // u = f x r
  logic signed [G_W-1:0]      g3_r [6];
  logic [2:0][UNIT_W-1:0]     r3_r, f3_r;
  logic                       v3_r;
  logic signed [G_W:0]        ud [3];
  logic [G_W:0]               umag [3];
  logic [G_W:0]               urnd [3];
  logic signed [Q_W-1:0]      u4_r [3];
  logic signed [Q_W-1:0]      r4_r [3];
  logic signed [Q_W-1:0]      f4_r [3];
  logic                       v4_r;

  // trace and branch
  logic signed [Q_W-1:0]      tr;
  branch_t                    br;
  branch_t                    br5_r;
  logic signed [Q_W-1:0]      tr5_r;
  logic signed [Q_W-1:0]      m5_r [3][3];
  logic                       v5_r;

  logic [3:0][Q_W-1:0]        q6_r;
  logic [3:0][Q_W-1:0]        q_nxt;
  logic                       v6_r;

  // quaternion normalizer
  logic                       qv;
  logic [3:0][UNIT_W-1:0]     q_u;

  logic [3:0][QUAT_BITS-1:0]  qo;
  logic [UNIT_W-1:0]          qmag [4];
  logic [UNIT_W-1:0]          qrnd [4];
  logic                       out_valid_r;
  lrq_out_t                   out_data_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  lrq_norm #(.N(3), .VW(CW), .SW(3*CW)) u_fnorm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .val_i  ({in_data.forward_z, in_data.forward_y, in_data.forward_x}),
    .side_i ({in_data.up_z, in_data.up_y, in_data.up_x}),
    .vld_o  (fv),
    .unit_o (f_u),
    .side_o (f_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= $signed(f_side[1*CW +: CW]) * $signed(f_u[2]);
      p1_r[1] <= $signed(f_side[2*CW +: CW]) * $signed(f_u[1]);
      p1_r[2] <= $signed(f_side[2*CW +: CW]) * $signed(f_u[0]);
      p1_r[3] <= $signed(f_side[0*CW +: CW]) * $signed(f_u[2]);
      p1_r[4] <= $signed(f_side[0*CW +: CW]) * $signed(f_u[1]);
      p1_r[5] <= $signed(f_side[1*CW +: CW]) * $signed(f_u[0]);
      f1_r    <= f_u;
      rc2_r[0] <= RC_W'(p1_r[0]) - RC_W'(p1_r[1]);
      rc2_r[1] <= RC_W'(p1_r[2]) - RC_W'(p1_r[3]);
      rc2_r[2] <= RC_W'(p1_r[4]) - RC_W'(p1_r[5]);
      f2_r     <= f1_r;
    end
  end

  lrq_norm #(.N(3), .VW(RC_W), .SW(3*UNIT_W)) u_rnorm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2_r),
    .val_i  (rc2_r),
    .side_i (f2_r),
    .vld_o  (rv),
    .unit_o (r_u),
    .side_o (r_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g3_r[0] <= $signed(r_side[1*UNIT_W +: UNIT_W]) * $signed(r_u[2]);
      g3_r[1] <= $signed(r_side[2*UNIT_W +: UNIT_W]) * $signed(r_u[1]);
      g3_r[2] <= $signed(r_side[2*UNIT_W +: UNIT_W]) * $signed(r_u[0]);
      g3_r[3] <= $signed(r_side[0*UNIT_W +: UNIT_W]) * $signed(r_u[2]);
      g3_r[4] <= $signed(r_side[0*UNIT_W +: UNIT_W]) * $signed(r_u[1]);
      g3_r[5] <= $signed(r_side[1*UNIT_W +: UNIT_W]) * $signed(r_u[0]);
      r3_r    <= r_u;
      f3_r    <= r_side;
    end
  end

  // Q2.60 differences back to Q1.30, half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ud[i]   = (G_W+1)'(g3_r[2*i]) - (G_W+1)'(g3_r[2*i+1]);
      umag[i] = ud[i][G_W] ? (~ud[i]) + (G_W+1)'(1) : ud[i];
      urnd[i] = (umag[i] + ((G_W+1)'(1) << (FRAC - 1))) >> FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u4_r[i] <= ud[i][G_W] ? -Q_W'(urnd[i]) : Q_W'(urnd[i]);
        r4_r[i] <= Q_W'($signed(r3_r[i]));
        f4_r[i] <= Q_W'($signed(f3_r[i]));
      end
    end
  end

  // columns are right, up, forward
  always_comb begin
    tr = r4_r[0] + u4_r[1] + f4_r[2];
    if (tr > 0) begin
      br = BR_W;
    end else if (r4_r[0] > u4_r[1] && r4_r[0] > f4_r[2]) begin
      br = BR_X;
    end else if (u4_r[1] > f4_r[2]) begin
      br = BR_Y;
    end else begin
      br = BR_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      br5_r <= br;
      tr5_r <= tr;
      for (int i = 0; i < 3; i++) begin
        m5_r[i][0] <= r4_r[i];
        m5_r[i][1] <= u4_r[i];
        m5_r[i][2] <= f4_r[i];
      end
    end
  end

  always_comb begin
    case (br5_r)
      BR_W: begin
        q_nxt[0] = tr5_r + Q_W'(ONE);
        q_nxt[1] = m5_r[2][1] - m5_r[1][2];
        q_nxt[2] = m5_r[0][2] - m5_r[2][0];
        q_nxt[3] = m5_r[1][0] - m5_r[0][1];
      end
      BR_X: begin
        q_nxt[0] = m5_r[2][1] - m5_r[1][2];
        q_nxt[1] = Q_W'(ONE) + m5_r[0][0] - m5_r[1][1] - m5_r[2][2];
        q_nxt[2] = m5_r[0][1] + m5_r[1][0];
        q_nxt[3] = m5_r[0][2] + m5_r[2][0];
      end
      BR_Y: begin
        q_nxt[0] = m5_r[0][2] - m5_r[2][0];
        q_nxt[1] = m5_r[0][1] + m5_r[1][0];
        q_nxt[2] = Q_W'(ONE) + m5_r[1][1] - m5_r[0][0] - m5_r[2][2];
        q_nxt[3] = m5_r[1][2] + m5_r[2][1];
      end
      default: begin
        q_nxt[0] = m5_r[1][0] - m5_r[0][1];
        q_nxt[1] = m5_r[0][2] + m5_r[2][0];
        q_nxt[2] = m5_r[1][2] + m5_r[2][1];
        q_nxt[3] = Q_W'(ONE) + m5_r[2][2] - m5_r[0][0] - m5_r[1][1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) q6_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= fv;
      v2_r <= v1_r;
      v3_r <= rv;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  lrq_norm #(.N(4), .VW(Q_W), .SW(1)) u_qnorm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v6_r),
    .val_i  (q6_r),
    .side_i (1'b0),
    .vld_o  (qv),
    .unit_o (q_u),
    .side_o ()
  );

  // Q1.30 to Q1.14, half away from zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmag[i] = q_u[i][UNIT_W-1] ? (~q_u[i]) + UNIT_W'(1) : q_u[i];
      qrnd[i] = (qmag[i] + (UNIT_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      qo[i]   = q_u[i][UNIT_W-1] ? -QUAT_BITS'(qrnd[i]) : QUAT_BITS'(qrnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.quat_w <= qo[0];
      out_data_r.quat_x <= qo[1];
      out_data_r.quat_y <= qo[2];
      out_data_r.quat_z <= qo[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output beat is stalled");

  a_quat_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_w <= QUAT_ONE && out_data.quat_w >= -QUAT_ONE))
    else $error("quat_w outside unit range");

  a_quat_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.quat_z <= QUAT_ONE && out_data.quat_z >= -QUAT_ONE))
    else $error("quat_z outside unit range");

endmodule

>>> dv/tb_look_rotation_quaternion_unit.sv
// Testbench for look_rotation_quaternion_unit: random and directed look vectors,
// results checked against a bit-exact fixed-point quaternion predictor.
// Depends on lrq_pkg and the unit's RTL.
module tb_look_rotation_quaternion_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lrq_pkg::*;

  localparam int LATENCY    = 217;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1600;
  localparam longint ONE_Q30 = longint'(1) <<< 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lrq_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lrq_out_t  out_data;

  look_rotation_quaternion_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  lrq_in_t  look_q[$];      // vectors waiting to be sent
  lrq_out_t quat_q[$];      // expected quaternions, oldest first
  int       drain_at[$];    // beat indexes before which the sender drains
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       in_took = 1'b0;

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint round_shift(longint v, int k);
    logic [63:0] m;
    m = (mag64(v) + (64'd1 << (k - 1))) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale to a unit vector in Q1.30; zero stays zero.
  function automatic void to_unit(input longint v[4], input int n, output longint o[4]);
    logic [63:0] m[4];
    logic [63:0] mx, sum, len, c;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      o[i] = 0;
      m[i] = (i < n) ? mag64(v[i]) : 64'd0;
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < n; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < n; i++) begin
      c = ((m[i] << 30) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(c) : longint'(c);
    end
  endfunction

  function automatic lrq_out_t look_to_quat(lrq_in_t d);
    longint fw[4], up[4], f[4], rc[4], r[4], u[4], q[4], qn[4];
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
    lrq_out_t res;
    fw = '{longint'(d.forward_x), longint'(d.forward_y), longint'(d.forward_z), 0};
    up = '{longint'(d.up_x), longint'(d.up_y), longint'(d.up_z), 0};
    to_unit(fw, 3, f);
    rc[0] = up[1] * f[2] - up[2] * f[1];
    rc[1] = up[2] * f[0] - up[0] * f[2];
    rc[2] = up[0] * f[1] - up[1] * f[0];
    rc[3] = 0;
    to_unit(rc, 3, r);
    u[0] = round_shift(f[1] * r[2] - f[2] * r[1], 30);
    u[1] = round_shift(f[2] * r[0] - f[0] * r[2], 30);
    u[2] = round_shift(f[0] * r[1] - f[1] * r[0], 30);
    m00 = r[0]; m01 = u[0]; m02 = f[0];
    m10 = r[1]; m11 = u[1]; m12 = f[1];
    m20 = r[2]; m21 = u[2]; m22 = f[2];
    tr = m00 + m11 + m22;
    if (tr > 0) begin
      q = '{tr + ONE_Q30, m21 - m12, m02 - m20, m10 - m01};
    end else if (m00 > m11 && m00 > m22) begin
      q = '{m21 - m12, ONE_Q30 + m00 - m11 - m22, m01 + m10, m02 + m20};
    end else if (m11 > m22) begin
      q = '{m02 - m20, m01 + m10, ONE_Q30 + m11 - m00 - m22, m12 + m21};
    end else begin
      q = '{m10 - m01, m02 + m20, m12 + m21, ONE_Q30 + m22 - m00 - m11};
    end
    to_unit(q, 4, qn);
    res.quat_w = 16'(round_shift(qn[0], 16));
    res.quat_x = 16'(round_shift(qn[1], 16));
    res.quat_y = 16'(round_shift(qn[2], 16));
    res.quat_z = 16'(round_shift(qn[3], 16));
    return res;
  endfunction

  function automatic lrq_in_t make_look(int fx, int fy, int fz, int ux, int uy, int uz);
    lrq_in_t d;
    d.forward_x = 16'(fx); d.forward_y = 16'(fy); d.forward_z = 16'(fz);
    d.up_x = 16'(ux); d.up_y = 16'(uy); d.up_z = 16'(uz);
    return d;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 8192)) - 4096);   // near unit length
      2: return 16'($signed($urandom_range(0, 64)) - 32);       // tiny magnitudes
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  // Stimulus
  initial begin
    lrq_in_t d;
    int k;
    // identity-ish looks and the W, X and Y quaternion branches
    look_q = {look_q, make_look(0, 0, 4096, 0, 4096, 0)};
    look_q = {look_q, make_look(0, 0, -4096, 0, 4096, 0)};
    look_q = {look_q, make_look(4096, 0, 0, 0, 4096, 0)};
    look_q = {look_q, make_look(-4096, 0, 0, 0, 4096, 0)};
    look_q = {look_q, make_look(0, 4096, 0, 0, 0, -4096)};
    look_q = {look_q, make_look(0, -4096, 0, 0, 0, 4096)};
    look_q = {look_q, make_look(0, 0, -4096, 0, -4096, 0)};
    look_q = {look_q, make_look(0, 0, -4096, 4096, 0, 0)};
    // zero forward, zero up, up parallel / antiparallel to forward
    look_q = {look_q, make_look(0, 0, 0, 0, 4096, 0)};
    look_q = {look_q, make_look(0, 0, 0, 0, 0, 0)};
    look_q = {look_q, make_look(1000, -2000, 3000, 0, 0, 0)};
    look_q = {look_q, make_look(1000, -2000, 3000, 2000, -4000, 6000)};
    look_q = {look_q, make_look(0, 4096, 0, 0, -4096, 0)};
    // field extremes
    look_q = {look_q, make_look(32767, 32767, 32767, -32768, -32768, -32768)};
    look_q = {look_q, make_look(-32768, -32768, -32768, 32767, 32767, 32767)};
    look_q = {look_q, make_look(-32768, 0, 0, 0, -32768, 0)};
    look_q = {look_q, make_look(32767, -32768, 1, -1, 32767, 0)};
    look_q = {look_q, make_look(1, 0, 0, 0, 1, 0)};
    look_q = {look_q, make_look(-1, -1, -1, 1, -1, 1)};
    look_q = {look_q, make_look(0, 0, 1, 0, 0, -1)};
    look_q = {look_q, make_look(32767, 32767, 0, -32768, 32767, 0)};
    drain_at = {drain_at, look_q.size()};
    drain_at = {drain_at, look_q.size() + N_RANDOM / 2};
    for (int i = 0; i < N_RANDOM; i++) begin
      d = make_look(0, 0, 0, 0, 0, 0);
      d.forward_x = rand_comp(); d.forward_y = rand_comp(); d.forward_z = rand_comp();
      d.up_x = rand_comp(); d.up_y = rand_comp(); d.up_z = rand_comp();
      k = $urandom_range(0, 9);
      if (k == 0) begin
        // up hint a scaled copy of forward
        d.up_x = 16'($signed(d.forward_x) >>> 1);
        d.up_y = 16'($signed(d.forward_y) >>> 1);
        d.up_z = 16'($signed(d.forward_z) >>> 1);
      end else if (k == 1) begin
        d.forward_x = 0; d.forward_y = 0; d.forward_z = 0;
      end
      look_q = {look_q, d};
    end
    stim_done = 1'b1;
  end

  // Sender: bursts and gaps, drains the pipe at chosen beats
  int  gap_left = 0;
  int  burst_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (drain_at.size() > 0 && n_sent == drain_at[0] && quat_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (look_q.size() > 0) begin
        if (drain_at.size() > 0 && n_sent == drain_at[0]) void'(drain_at.pop_front());
        in_data <= look_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches mode now and then
  int stall_mode = 0;
  int stall_timer = 0;
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  // Accept side and result check, sampled at the rising edge
  always @(posedge clk) begin
    lrq_out_t want;
    bit took;
    bit moved;
    took = 1'b0;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        quat_q = {quat_q, look_to_quat(in_data)};
        n_sent <= n_sent + 1;
        took = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (quat_q.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("unexpected beat: got %p", out_data);
        end else begin
          want = quat_q.pop_front();
          n_checked <= n_checked + 1;
          if (out_data !== want) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("mismatch beat %0d: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                       n_checked, want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                       out_data.quat_w, out_data.quat_x, out_data.quat_y, out_data.quat_z);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
    in_took <= took;
  end

  // Watchdog: too long with no beat on either side
  always @(posedge clk) begin
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: %0d beats pending", quat_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && look_q.size() == 0 && !in_valid && quat_q.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);
    $display("sent %0d look vectors (directed branches, degenerate and extreme cases, random)",
             n_sent);
    $display("checked %0d quaternions under random gaps and stalls, %0d errors",
             n_checked, n_errors);
    if (n_errors == 0 && quat_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
